// File: sv/dwpc_pkg.sv
// Shared types and constants for the DAG worst-path cost block.
// Used by dwpc_eval and dag_worst_path_cost; depends on nothing.
package dwpc_pkg;

  localparam int ID_BITS        = 8;
  localparam int PORT_COST_BITS = 48;
  localparam int EPOCH_BITS     = 8;

  localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_BAD  = 2'd3;

  typedef struct packed {
    logic       is_dummy;
    logic       is_loop_head;
    logic [1:0] succ_count;
    logic       succ0_other_loop;
    logic       succ1_other_loop;
    logic       last_item;
  } item_flags_t;

  typedef struct packed {
    logic edge_error;
    logic write_en;
  } eval_status_t;

endpackage

// File: sv/dwpc_store.sv
// Cost store: synchronous memory with two registered read ports and one write port.
// Each word holds an epoch tag above the stored cost; depends on nothing.
module dwpc_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 56
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_a_addr_i,
  input  logic [ADDR_W-1:0] rd_b_addr_i,
  output logic [DATA_W-1:0] rd_a_data_o,
  output logic [DATA_W-1:0] rd_b_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_a_q;
  logic [DATA_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_a_addr_i];
      rd_b_q <= mem_q[rd_b_addr_i];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// File: sv/dwpc_eval.sv
// Cost evaluation: picks the successor cost and adds it with saturation.
// Uses dwpc_pkg for the item flags, the status struct and the epoch width.
module dwpc_eval #(
  parameter int COST_BITS = 48
) (
  input  dwpc_pkg::item_flags_t                   flags_i,
  input  logic [COST_BITS-1:0]                    base_i,
  input  logic [dwpc_pkg::EPOCH_BITS-1:0]         epoch_i,
  input  logic [dwpc_pkg::EPOCH_BITS+COST_BITS-1:0] rd_a_i,
  input  logic [dwpc_pkg::EPOCH_BITS+COST_BITS-1:0] rd_b_i,
  output logic [COST_BITS-1:0]                    cost_o,
  output dwpc_pkg::eval_status_t                  status_o
);

  localparam int WORD_W = dwpc_pkg::EPOCH_BITS + COST_BITS;

  logic                 hit_a;
  logic                 hit_b;
  logic [COST_BITS-1:0] c0;
  logic [COST_BITS-1:0] c1;
  logic [COST_BITS-1:0] pick;
  logic [COST_BITS-1:0] addend;
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] sat_sum;

  assign hit_a = rd_a_i[WORD_W-1 -: dwpc_pkg::EPOCH_BITS] == epoch_i;
  assign hit_b = rd_b_i[WORD_W-1 -: dwpc_pkg::EPOCH_BITS] == epoch_i;
  assign c0    = hit_a ? rd_a_i[COST_BITS-1:0] : '0;
  assign c1    = hit_b ? rd_b_i[COST_BITS-1:0] : '0;

  always_comb begin
    priority if (flags_i.succ0_other_loop) begin
      pick = c1;
    end else if (flags_i.succ1_other_loop) begin
      pick = c0;
    end else begin
      pick = (c0 >= c1) ? c0 : c1;
    end
  end

  always_comb begin
    if (flags_i.is_loop_head) begin
      addend = c0;
    end else begin
      unique case (flags_i.succ_count)
        dwpc_pkg::CNT_NONE: addend = '0;
        dwpc_pkg::CNT_ONE:  addend = c0;
        dwpc_pkg::CNT_TWO:  addend = pick;
        dwpc_pkg::CNT_BAD:  addend = '0;
        default:            addend = '0;
      endcase
    end
  end

  assign sum     = {1'b0, base_i} + {1'b0, addend};
  assign sat_sum = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];

  always_comb begin
    priority if (flags_i.is_dummy) begin
      cost_o              = c1;
      status_o.edge_error = 1'b0;
      status_o.write_en   = 1'b0;
    end else if (flags_i.is_loop_head) begin
      cost_o              = sat_sum;
      status_o.edge_error = 1'b0;
      status_o.write_en   = 1'b1;
    end else if (flags_i.succ_count == dwpc_pkg::CNT_BAD) begin
      cost_o              = '0;
      status_o.edge_error = 1'b1;
      status_o.write_en   = 1'b0;
    end else begin
      cost_o              = sat_sum;
      status_o.edge_error = 1'b0;
      status_o.write_en   = 1'b1;
    end
  end

endmodule

// File: sv/dag_worst_path_cost.sv
// Top level of the DAG worst-path cost block: control sequencer and output register.
// Uses dwpc_pkg, dwpc_store and dwpc_eval.
//
// Blocks of a control-flow DAG arrive on the input channel in reverse topological
// order, one beat per block, and the worst path cost of each block is kept in an
// on-chip cost store. Both channels use valid and stall; a beat moves at a clock
// edge where valid is high and stall is low.
// A beat is taken only while the sequencer is idle. It reads both successor entries
// at the accepting edge. In the execute state, once the output register is free, the
// saturated cost is written back (not for a dummy block or an edge error) and loaded
// into the output register and the sequencer returns to idle, so a new beat is taken
// only once the last block is through, set by the single store's read and write-back.
// A dummy block that is not the last one gives no result beat.
// The output register frees the input side: a new beat may be taken while a result
// waits. If the receiver stalls and a new result is ready, the sequencer holds it
// with input stall high until the output register is free.
// Valid marks are epoch tags in the store. After reset, and after every 255th last
// item, a clearing pass writes every entry while input stall stays high.
module dag_worst_path_cost #(
  parameter int BLOCKS    = 256,
  parameter int COST_BITS = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dwpc_pkg::ID_BITS-1:0]         node_id_i,
  input  logic                                 is_dummy_i,
  input  logic                                 is_loop_head_i,
  input  logic [dwpc_pkg::PORT_COST_BITS-1:0]  own_cost_i,
  input  logic [dwpc_pkg::PORT_COST_BITS-1:0]  added_cost_i,
  input  logic [1:0]                           succ_count_i,
  input  logic [dwpc_pkg::ID_BITS-1:0]         succ0_id_i,
  input  logic [dwpc_pkg::ID_BITS-1:0]         succ1_id_i,
  input  logic                                 succ0_other_loop_i,
  input  logic                                 succ1_other_loop_i,
  input  logic                                 last_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dwpc_pkg::ID_BITS-1:0]         result_node_o,
  output logic [dwpc_pkg::PORT_COST_BITS-1:0]  path_cost_o,
  output logic                                 is_total_o,
  output logic                                 edge_error_o
);

  localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int WORD_W = dwpc_pkg::EPOCH_BITS + COST_BITS;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCKS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  function automatic logic [IDX_W-1:0] slot_of(input logic [dwpc_pkg::ID_BITS-1:0] id);
    logic [23:0] v;
    v = {16'b0, id};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (24'(BLOCKS) << k)) begin
        v = v - (24'(BLOCKS) << k);
      end
    end
    return v[IDX_W-1:0];
  endfunction

  state_e                         state_q;
  logic [IDX_W-1:0]               clr_idx_q;
  logic [dwpc_pkg::EPOCH_BITS-1:0] epoch_q;
  dwpc_pkg::item_flags_t          flags_q;
  logic [dwpc_pkg::ID_BITS-1:0]   node_q;
  logic [IDX_W-1:0]               node_slot_q;
  logic [COST_BITS-1:0]           base_q;
  logic                           out_valid_q;
  logic [dwpc_pkg::ID_BITS-1:0]   out_node_q;
  logic [COST_BITS-1:0]           out_cost_q;
  logic                           out_total_q;
  logic                           out_error_q;

  logic                           accept;
  logic                           out_free;
  logic                           produce;
  logic                           load;
  logic [COST_BITS-1:0]           own_c;
  logic [COST_BITS-1:0]           added_c;
  logic [COST_BITS:0]             base_sum;
  logic [COST_BITS-1:0]           base_d;
  dwpc_pkg::item_flags_t          flags_d;
  logic [IDX_W-1:0]               rd_a_addr;
  logic [IDX_W-1:0]               rd_b_addr;
  logic [WORD_W-1:0]              rd_a_data;
  logic [WORD_W-1:0]              rd_b_data;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  logic [WORD_W-1:0]              mem_wdata;
  logic [COST_BITS-1:0]           eval_cost;
  dwpc_pkg::eval_status_t         eval_status;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign own_c    = COST_BITS'(own_cost_i);
  assign added_c  = COST_BITS'(added_cost_i);
  assign base_sum = {1'b0, own_c} + {1'b0, added_c};
  assign base_d   = base_sum[COST_BITS] ? '1 : base_sum[COST_BITS-1:0];

  assign flags_d.is_dummy         = is_dummy_i;
  assign flags_d.is_loop_head     = is_loop_head_i;
  assign flags_d.succ_count       = succ_count_i;
  assign flags_d.succ0_other_loop = succ0_other_loop_i;
  assign flags_d.succ1_other_loop = succ1_other_loop_i;
  assign flags_d.last_item        = last_item_i;

  assign rd_a_addr = slot_of(succ0_id_i);
  assign rd_b_addr = is_dummy_i ? slot_of(node_id_i) : slot_of(succ1_id_i);

  assign out_free = !out_valid_q || !out_stall_i;
  assign produce  = !flags_q.is_dummy || flags_q.last_item;
  assign load     = (state_q == ST_EXEC) && produce && out_free;

  assign mem_we    = (state_q == ST_CLEAR) || (load && eval_status.write_en);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_idx_q : node_slot_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? {dwpc_pkg::EPOCH_NONE, {COST_BITS{1'b0}}}
                                           : {epoch_q, eval_cost};

  dwpc_store #(
    .DEPTH  (BLOCKS),
    .ADDR_W (IDX_W),
    .DATA_W (WORD_W)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data),
    .wr_en_i     (mem_we),
    .wr_addr_i   (mem_waddr),
    .wr_data_i   (mem_wdata)
  );

  dwpc_eval #(
    .COST_BITS (COST_BITS)
  ) u_eval (
    .flags_i  (flags_q),
    .base_i   (base_q),
    .epoch_i  (epoch_q),
    .rd_a_i   (rd_a_data),
    .rd_b_i   (rd_b_data),
    .cost_o   (eval_cost),
    .status_o (eval_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      epoch_q     <= dwpc_pkg::EPOCH_FIRST;
      flags_q     <= '0;
      node_q      <= '0;
      node_slot_q <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      out_node_q  <= '0;
      out_cost_q  <= '0;
      out_total_q <= 1'b0;
      out_error_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_idx_q == IDX_LAST) begin
            clr_idx_q <= '0;
            epoch_q   <= dwpc_pkg::EPOCH_FIRST;
            state_q   <= ST_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            flags_q     <= flags_d;
            node_q      <= node_id_i;
            node_slot_q <= slot_of(node_id_i);
            base_q      <= base_d;
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!produce) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_node_q  <= node_q;
            out_cost_q  <= eval_cost;
            out_total_q <= flags_q.last_item;
            out_error_q <= eval_status.edge_error;
            if (flags_q.last_item && (epoch_q == dwpc_pkg::EPOCH_LAST)) begin
              clr_idx_q <= '0;
              state_q   <= ST_CLEAR;
            end else begin
              if (flags_q.last_item) begin
                epoch_q <= epoch_q + dwpc_pkg::EPOCH_BITS'(1);
              end
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_node_o = out_node_q;
  assign path_cost_o   = dwpc_pkg::PORT_COST_BITS'(out_cost_q);
  assign is_total_o    = out_total_q;
  assign edge_error_o  = out_error_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("Accepted beat did not move the sequencer to execution.");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != dwpc_pkg::EPOCH_NONE)
    else $error("Epoch tag took the reserved empty value.");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != ST_IDLE))
    else $error("Cost store written while the sequencer was idle.");

  a_last_bumps_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && flags_q.last_item && (epoch_q != dwpc_pkg::EPOCH_LAST))
      |=> (epoch_q != $past(epoch_q)))
    else $error("Last block did not invalidate the stored costs.");

  a_error_zero_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && edge_error_o) |-> (path_cost_o == '0))
    else $error("Edge error beat carries a nonzero cost.");

endmodule
